// ===== rtl/mcat_pkg.sv =====
// Shared types, codes and constants of the auto-off timer bank.
// No dependencies; the front end, back end and top level refer to it by scoped names.
package mcat_pkg;

  localparam int CHANNELS_DEF   = 16;
  localparam int CMDQ_DEPTH_DEF = 2;
  localparam int OUTQ_DEPTH_DEF = 4;

  localparam logic       NO_TURN_ON_RST = 1'b0;
  localparam logic [3:0] TURN_ON_RST    = 4'd5;
  localparam logic [3:0] GIVE_UP_RST    = 4'd10;

  localparam logic [15:0] HALF_MIN    = 16'd30;
  localparam logic [15:0] RECIP_60    = 16'd34953;
  localparam int          RECIP_SHIFT = 21;

  typedef enum logic [1:0] {
    REG_NO_TURN_ON = 2'd0,
    REG_TURN_ON    = 2'd1,
    REG_GIVE_UP    = 2'd2
  } reg_idx_e;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_START = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_QUERY = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_ON      = 2'd0,
    KIND_OFF     = 2'd1,
    KIND_SUMMARY = 2'd2,
    KIND_QUERY   = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_WALK,
    BK_SUM,
    BK_QDIFF,
    BK_QMUL,
    BK_QOUT
  } bk_st_e;

  typedef struct packed {
    cmd_e        command;
    logic [3:0]  channel;
    logic [9:0]  duration_minutes;
    logic [5:0]  duration_seconds;
    logic [15:0] device_on_mask;
  } in_item_t;

  typedef struct packed {
    kind_e       kind;
    logic [3:0]  target_channel;
    logic        any_counting;
    logic [15:0] active_mask;
    logic [9:0]  minutes_left;
    logic [15:0] seconds_left;
    logic        last_of_run;
  } out_item_t;

  typedef struct packed {
    logic       no_turn_on_mode;
    logic [3:0] turn_on_tick;
    logic [3:0] give_up_tick;
  } cfg_t;

  typedef struct packed {
    cmd_e        op;
    logic [3:0]  chan;
    logic        in_range;
    logic        zero;
    logic [15:0] total;
    logic [5:0]  secs;
    logic [15:0] dev_mask;
  } dec_t;

endpackage

// ===== rtl/mcat_fifo.sv =====
// Small first-in first-out queue of flop entries, head word shown while not empty.
// Generic width and depth; no package dependency.
module mcat_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_wr, do_rd;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// ===== rtl/mcat_front.sv =====
// Front end: decodes an input word into a command for the back end.
// Depends on mcat_pkg.
module mcat_front #(
  parameter int CHANNELS = mcat_pkg::CHANNELS_DEF
) (
  input  logic               push,
  input  mcat_pkg::in_item_t in_word,
  output logic               q_wr,
  output mcat_pkg::dec_t     q_data
);

  localparam logic [6:0] CH_LIMIT = 7'(CHANNELS);

  logic [15:0] total;

  assign total = {in_word.duration_minutes, 6'b0}
               - {4'b0, in_word.duration_minutes, 2'b0}
               + {10'b0, in_word.duration_seconds};

  assign q_wr = push;

  always_comb begin
    q_data          = '0;
    q_data.op       = in_word.command;
    q_data.chan     = in_word.channel;
    q_data.in_range = ({3'b0, in_word.channel} < CH_LIMIT);
    q_data.zero     = (total == '0);
    q_data.total    = total;
    q_data.secs     = in_word.duration_seconds;
    q_data.dev_mask = in_word.device_on_mask;
  end

endmodule

// ===== rtl/mcat_back.sv =====
// Back end: per-channel timer state and the sequencer that runs commands.
// Depends on mcat_pkg; takes decoded words from the command queue.
module mcat_back #(
  parameter int CHANNELS = mcat_pkg::CHANNELS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  mcat_pkg::cfg_t      cfg,
  input  logic                cmd_empty,
  input  mcat_pkg::dec_t      cmd_word,
  output logic                cmd_pop,
  input  logic                out_full,
  output logic                out_push,
  output mcat_pkg::out_item_t out_word
);

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic        act_r  [CHANNELS];
  logic        act_nxt[CHANNELS];
  logic        cd_r   [CHANNELS];
  logic        cd_nxt [CHANNELS];
  logic [3:0]  wait_r   [CHANNELS];
  logic [3:0]  wait_nxt [CHANNELS];
  logic [15:0] tot_r    [CHANNELS];
  logic [15:0] tot_nxt  [CHANNELS];
  logic [5:0]  sec_r    [CHANNELS];
  logic [5:0]  sec_nxt  [CHANNELS];
  logic [15:0] left_r   [CHANNELS];
  logic [15:0] left_nxt [CHANNELS];
  logic [15:0] el_r     [CHANNELS];
  logic [15:0] el_nxt   [CHANNELS];

  mcat_pkg::bk_st_e st_r, st_nxt;
  mcat_pkg::dec_t   cur_r, cur_nxt;
  logic [CH_W-1:0]  idx_r, idx_nxt;
  logic [15:0]      mask_r, mask_nxt;
  logic [15:0]      qm_r, qm_nxt;
  logic [15:0]      qs_r, qs_nxt;
  logic [31:0]      prod_r, prod_nxt;

  logic [CH_W-1:0] sel;
  logic [6:0]      sel7;
  logic            s_act, s_cd;
  logic [3:0]      s_wait, w_inc;
  logic [15:0]     s_tot, s_left, s_el, el_inc, left_dec, num;
  logic [5:0]      s_sec;
  logic            dev, req_on, give, begin_cd, cd_done, req_off, w_emit, w_stall;
  logic            c_dev, any_cnt;
  logic [15:0]     act_mask, fin_mask;

  always_comb begin
    if (st_r == mcat_pkg::BK_WALK) begin
      sel = idx_r;
    end else if (st_r == mcat_pkg::BK_IDLE) begin
      sel = CH_W'(cmd_word.chan);
    end else begin
      sel = CH_W'(cur_r.chan);
    end
  end

  assign sel7   = 7'(sel);
  assign s_act  = act_r[sel];
  assign s_cd   = cd_r[sel];
  assign s_wait = wait_r[sel];
  assign s_tot  = tot_r[sel];
  assign s_sec  = sec_r[sel];
  assign s_left = left_r[sel];
  assign s_el   = el_r[sel];

  assign el_inc   = (s_el == 16'hFFFF) ? s_el : s_el + 16'd1;
  assign left_dec = s_left - 16'd1;
  assign w_inc    = s_wait + 4'd1;
  assign dev      = (sel7 < 7'd16) && cur_r.dev_mask[sel7[3:0]];
  assign req_on   = !s_cd && (s_wait == cfg.turn_on_tick) && !cfg.no_turn_on_mode;
  assign give     = !s_cd && !req_on && (w_inc == cfg.give_up_tick);
  assign begin_cd = !s_cd && (give || dev);
  assign cd_done  = s_cd && (left_dec == '0);
  assign req_off  = cd_done && dev;
  assign w_emit   = s_act && (req_on || req_off);
  assign w_stall  = w_emit && out_full;
  assign c_dev    = cmd_word.dev_mask[cmd_word.chan];
  assign num      = s_tot - {10'b0, s_sec} + mcat_pkg::HALF_MIN;

  for (genvar i = 0; i < 16; i++) begin : g_mask
    if (i < CHANNELS) begin : g_on
      assign act_mask[i] = act_r[i];
      assign fin_mask[i] = act_r[i] && !(cd_r[i] && (left_r[i] == 16'd1));
    end else begin : g_off
      assign act_mask[i] = 1'b0;
      assign fin_mask[i] = 1'b0;
    end
  end

  always_comb begin
    any_cnt = 1'b0;
    for (int i = 0; i < CHANNELS; i++) begin
      any_cnt = any_cnt | (act_r[i] & cd_r[i]);
    end
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      mcat_pkg::BK_IDLE: begin
        if (!cmd_empty) begin
          case (cmd_word.op)
            mcat_pkg::CMD_TICK:  st_nxt = mcat_pkg::BK_WALK;
            mcat_pkg::CMD_QUERY: st_nxt = mcat_pkg::BK_QDIFF;
            default:             st_nxt = mcat_pkg::BK_IDLE;
          endcase
        end
      end
      mcat_pkg::BK_WALK: begin
        if (!w_stall && idx_r == CH_W'(CHANNELS - 1)) begin
          st_nxt = mcat_pkg::BK_SUM;
        end
      end
      mcat_pkg::BK_SUM: begin
        if (!out_full) begin
          st_nxt = mcat_pkg::BK_IDLE;
        end
      end
      mcat_pkg::BK_QDIFF: st_nxt = mcat_pkg::BK_QMUL;
      mcat_pkg::BK_QMUL:  st_nxt = mcat_pkg::BK_QOUT;
      mcat_pkg::BK_QOUT: begin
        if (!out_full) begin
          st_nxt = mcat_pkg::BK_IDLE;
        end
      end
      default: st_nxt = mcat_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    act_nxt  = act_r;
    cd_nxt   = cd_r;
    wait_nxt = wait_r;
    tot_nxt  = tot_r;
    sec_nxt  = sec_r;
    left_nxt = left_r;
    el_nxt   = el_r;
    cur_nxt  = cur_r;
    idx_nxt  = idx_r;
    mask_nxt = mask_r;
    qm_nxt   = qm_r;
    qs_nxt   = qs_r;
    prod_nxt = prod_r;
    cmd_pop  = 1'b0;
    out_push = 1'b0;
    out_word = '0;
    case (st_r)
      mcat_pkg::BK_IDLE: begin
        if (!cmd_empty) begin
          cmd_pop  = 1'b1;
          cur_nxt  = cmd_word;
          idx_nxt  = '0;
          mask_nxt = fin_mask;
          case (cmd_word.op)
            mcat_pkg::CMD_START: begin
              if (cmd_word.in_range) begin
                if (cmd_word.zero) begin
                  act_nxt[sel] = 1'b0;
                end else if (s_act) begin
                  tot_nxt[sel] = cmd_word.total;
                  sec_nxt[sel] = cmd_word.secs;
                  if (s_cd) begin
                    left_nxt[sel] = cmd_word.total;
                    el_nxt[sel]   = '0;
                  end
                end else begin
                  act_nxt[sel]  = 1'b1;
                  cd_nxt[sel]   = c_dev;
                  wait_nxt[sel] = '0;
                  el_nxt[sel]   = '0;
                  tot_nxt[sel]  = cmd_word.total;
                  sec_nxt[sel]  = cmd_word.secs;
                  left_nxt[sel] = cmd_word.total;
                end
              end
            end
            mcat_pkg::CMD_CLEAR: begin
              if (cmd_word.in_range) begin
                act_nxt[sel] = 1'b0;
              end
            end
            default: ;
          endcase
        end
      end
      mcat_pkg::BK_WALK: begin
        if (!w_stall) begin
          idx_nxt = idx_r + 1'b1;
          if (s_act) begin
            el_nxt[sel] = el_inc;
            if (s_cd) begin
              left_nxt[sel] = left_dec;
              if (cd_done) begin
                act_nxt[sel] = 1'b0;
              end
            end else begin
              wait_nxt[sel] = w_inc;
              if (begin_cd) begin
                cd_nxt[sel]   = 1'b1;
                left_nxt[sel] = s_tot;
                el_nxt[sel]   = '0;
              end
            end
            if (w_emit) begin
              out_push                = 1'b1;
              out_word.kind           = req_on ? mcat_pkg::KIND_ON : mcat_pkg::KIND_OFF;
              out_word.target_channel = sel7[3:0];
              out_word.active_mask    = mask_r;
            end
          end
        end
      end
      mcat_pkg::BK_SUM: begin
        out_push              = !out_full;
        out_word.kind         = mcat_pkg::KIND_SUMMARY;
        out_word.any_counting = any_cnt;
        out_word.active_mask  = act_mask;
        out_word.last_of_run  = 1'b1;
      end
      mcat_pkg::BK_QDIFF: begin
        qm_nxt = '0;
        qs_nxt = '0;
        if (cur_r.in_range && s_act) begin
          if (num > s_el) begin
            qm_nxt = num - s_el;
          end
          if (s_tot > s_el) begin
            qs_nxt = s_tot - s_el;
          end
        end
      end
      mcat_pkg::BK_QMUL: begin
        prod_nxt = 32'(qm_r) * 32'(mcat_pkg::RECIP_60);
      end
      mcat_pkg::BK_QOUT: begin
        out_push                = !out_full;
        out_word.kind           = mcat_pkg::KIND_QUERY;
        out_word.target_channel = cur_r.chan;
        out_word.active_mask    = act_mask;
        out_word.minutes_left   = prod_r[mcat_pkg::RECIP_SHIFT +: 10];
        out_word.seconds_left   = qs_r;
        out_word.last_of_run    = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= mcat_pkg::BK_IDLE;
      act_r  <= '{default: 1'b0};
    end else begin
      st_r   <= st_nxt;
      act_r  <= act_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cd_r   <= cd_nxt;
    wait_r <= wait_nxt;
    tot_r  <= tot_nxt;
    sec_r  <= sec_nxt;
    left_r <= left_nxt;
    el_r   <= el_nxt;
    cur_r  <= cur_nxt;
    idx_r  <= idx_nxt;
    mask_r <= mask_nxt;
    qm_r   <= qm_nxt;
    qs_r   <= qs_nxt;
    prod_r <= prod_nxt;
  end

endmodule

// ===== rtl/multi_channel_auto_off_timer.sv =====
// Top level of the auto-off timer bank: configuration registers, front end,
// command queue, back end and result queue. Depends on mcat_pkg and all mcat_ modules.
//
// Commands enter through a queue and are run one at a time by the back-end sequencer.
// Start and clear are done in the idle state; a query passes through the difference,
// multiply and output states; a tick visits one channel per cycle, pausing while a
// request waits on a full result queue, and then emits a summary. Any request, summary
// or query answer waits while the result queue is full. Results collect in an output
// queue, and the input side keeps accepting until the command queue fills behind a
// busy or stalled back end. Every result of a tick carries the active mask as it
// stands once the whole tick is done.
module multi_channel_auto_off_timer #(
  parameter int CHANNELS   = mcat_pkg::CHANNELS_DEF,
  parameter int CMDQ_DEPTH = mcat_pkg::CMDQ_DEPTH_DEF,
  parameter int OUTQ_DEPTH = mcat_pkg::OUTQ_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  output logic                full,
  input  mcat_pkg::in_item_t  in_word,
  output logic                empty,
  input  logic                pop,
  output mcat_pkg::out_item_t out_word,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [3:0]          cfg_wdata
);

  localparam int DEC_W = $bits(mcat_pkg::dec_t);
  localparam int OUT_W = $bits(mcat_pkg::out_item_t);

  mcat_pkg::cfg_t      cfg_r, cfg_nxt;
  logic                q_wr;
  mcat_pkg::dec_t      q_data;
  logic                cmd_empty, cmd_pop;
  logic [DEC_W-1:0]    cmd_raw;
  mcat_pkg::dec_t      cmd_word;
  logic                res_full, res_push;
  mcat_pkg::out_item_t res_word;
  logic [OUT_W-1:0]    out_raw;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        mcat_pkg::REG_NO_TURN_ON: cfg_nxt.no_turn_on_mode = cfg_wdata[0];
        mcat_pkg::REG_TURN_ON:    cfg_nxt.turn_on_tick    = cfg_wdata;
        mcat_pkg::REG_GIVE_UP:    cfg_nxt.give_up_tick    = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.no_turn_on_mode <= mcat_pkg::NO_TURN_ON_RST;
      cfg_r.turn_on_tick    <= mcat_pkg::TURN_ON_RST;
      cfg_r.give_up_tick    <= mcat_pkg::GIVE_UP_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  mcat_front #(.CHANNELS(CHANNELS)) u_front (
    .push    (push),
    .in_word (in_word),
    .q_wr    (q_wr),
    .q_data  (q_data)
  );

  mcat_fifo #(.WIDTH(DEC_W), .DEPTH(CMDQ_DEPTH)) u_cmdq (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_wr),
    .wr_data (q_data),
    .full    (full),
    .rd_en   (cmd_pop),
    .rd_data (cmd_raw),
    .empty   (cmd_empty)
  );

  assign cmd_word = mcat_pkg::dec_t'(cmd_raw);

  mcat_back #(.CHANNELS(CHANNELS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .cmd_empty (cmd_empty),
    .cmd_word  (cmd_word),
    .cmd_pop   (cmd_pop),
    .out_full  (res_full),
    .out_push  (res_push),
    .out_word  (res_word)
  );

  mcat_fifo #(.WIDTH(OUT_W), .DEPTH(OUTQ_DEPTH)) u_outq (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (res_push),
    .wr_data (res_word),
    .full    (res_full),
    .rd_en   (pop),
    .rd_data (out_raw),
    .empty   (empty)
  );

  assign out_word = mcat_pkg::out_item_t'(out_raw);

endmodule
